// ----- design/gvh_pkg.sv -----
// shared constants, codes and control types of the grid visit histogram
package gvh_pkg;

    localparam int MAX_COLS      = 64;
    localparam int MAX_ROWS      = 64;
    localparam int COL_BITS      = $clog2(MAX_COLS);
    localparam int ROW_BITS      = $clog2(MAX_ROWS);
    localparam int ADDR_BITS     = COL_BITS + ROW_BITS;
    localparam int STORE_DEPTH   = MAX_COLS * MAX_ROWS;

    localparam int COUNT_BITS    = 16;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    localparam int UNIQUE_BITS   = $clog2(STORE_DEPTH + 1);
    localparam int TOTAL_BITS    = 28;
    localparam int Q8_BITS       = 8;
    localparam int AVG_BITS      = 24;
    localparam int DENS_BITS     = 15;
    localparam int AREA_BITS     = UNIQUE_BITS;
    localparam int DENS_NUM_BITS = UNIQUE_BITS + DENS_BITS;
    localparam int DENSITY_FULL  = 25600;

    localparam int OP_BITS       = 2;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 7;
    localparam logic [CFG_DATA_BITS-1:0] GRID_RESET = CFG_DATA_BITS'(64);

    localparam int DIV_R_BITS    = UNIQUE_BITS;
    localparam int DIV_Q_BITS    = AVG_BITS;
    localparam int DIV_CNT_BITS  = $clog2(DIV_Q_BITS + 1);
    localparam int AVG_STEPS     = AVG_BITS;
    localparam int DENS_STEPS    = DENS_BITS;

    typedef enum logic [OP_BITS-1:0] {
        OP_RECORD = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_GRID_WIDTH  = 2'd0,
        CFG_GRID_HEIGHT = 2'd1
    } cfg_idx_t;

    typedef struct packed {
        logic wipe_write;
        logic wipe_clear;
        logic rd_cell;
        logic upd_cell;
        logic prep;
        logic avg_start;
        logic avg_cap;
        logic dens_start;
        logic dens_cap;
        logic load_out;
    } gvh_cmd_t;

    typedef struct packed {
        logic wipe_last;
        logic div_done;
        logic out_free;
    } gvh_sts_t;

endpackage

// ----- design/gvh_if.sv -----
// request, response and configuration channel interfaces
interface gvh_req_if import gvh_pkg::*;;
    logic                valid;
    logic                ready;
    logic [OP_BITS-1:0]  opcode;
    logic [COL_BITS-1:0] cell_x;
    logic [ROW_BITS-1:0] cell_y;

    modport source (output valid, output opcode, output cell_x, output cell_y, input ready);
    modport sink   (input valid, input opcode, input cell_x, input cell_y, output ready);
endinterface

interface gvh_rsp_if import gvh_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [COUNT_BITS-1:0]  cell_count;
    logic [COUNT_BITS-1:0]  max_visits;
    logic [UNIQUE_BITS-1:0] unique_cells;
    logic [TOTAL_BITS-1:0]  total_visits;
    logic [AVG_BITS-1:0]    avg_visits_q8;
    logic [DENS_BITS-1:0]   density_q8;
    logic                   coord_error;

    modport source (output valid, output cell_count, output max_visits, output unique_cells,
                    output total_visits, output avg_visits_q8, output density_q8,
                    output coord_error, input ready);
    modport sink   (input valid, input cell_count, input max_visits, input unique_cells,
                    input total_visits, input avg_visits_q8, input density_q8,
                    input coord_error, output ready);
endinterface

interface gvh_cfg_if import gvh_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/gvh_div.sv -----
// shared restoring divider, one quotient bit per cycle
module gvh_div import gvh_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [DIV_R_BITS-1:0]   rem_init,
    input  logic [DIV_Q_BITS-1:0]   low_init,
    input  logic [DIV_CNT_BITS-1:0] steps,
    input  logic [DIV_R_BITS-1:0]   divisor,
    output logic                    done,
    output logic [DIV_Q_BITS-1:0]   quot
);

    logic                    busy_reg;
    logic                    done_reg;
    logic [DIV_CNT_BITS-1:0] cnt_reg;
    logic [DIV_R_BITS-1:0]   rem_reg;
    logic [DIV_Q_BITS-1:0]   low_reg;
    logic [DIV_Q_BITS-1:0]   quot_reg;
    logic [DIV_R_BITS-1:0]   div_reg;

    logic [DIV_R_BITS:0]     trial;
    logic [DIV_R_BITS:0]     diff;
    logic                    fits;

    assign trial = {rem_reg, low_reg[DIV_Q_BITS-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign fits  = trial >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= rem_init;
            low_reg  <= low_init;
            quot_reg <= '0;
            div_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? diff[DIV_R_BITS-1:0] : trial[DIV_R_BITS-1:0];
            low_reg  <= {low_reg[DIV_Q_BITS-2:0], 1'b0};
            quot_reg <= {quot_reg[DIV_Q_BITS-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ----- design/gvh_dp.sv -----
// datapath: count store, statistics, grid registers and result register
module gvh_dp import gvh_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  logic [OP_BITS-1:0]  in_opcode,
    input  logic [COL_BITS-1:0] in_x,
    input  logic [ROW_BITS-1:0] in_y,
    gvh_cfg_if.sink             cfg,
    gvh_rsp_if.source           rsp,
    input  gvh_cmd_t            cmd,
    output gvh_sts_t            sts
);

    logic [CFG_DATA_BITS-1:0] grid_w_reg;
    logic [CFG_DATA_BITS-1:0] grid_h_reg;

    op_t                      op_reg;
    logic [COL_BITS-1:0]      x_reg;
    logic [ROW_BITS-1:0]      y_reg;

    logic [COUNT_BITS-1:0]    mem [STORE_DEPTH];
    logic [COUNT_BITS-1:0]    rd_data_reg;
    logic [ADDR_BITS-1:0]     wipe_addr_reg;

    logic [COUNT_BITS-1:0]    max_reg;
    logic [UNIQUE_BITS-1:0]   unique_reg;
    logic [TOTAL_BITS-1:0]    total_reg;
    logic [COUNT_BITS-1:0]    cell_reg;
    logic                     err_reg;

    logic [AREA_BITS-1:0]     area_reg;
    logic [DENS_NUM_BITS-1:0] dens_num_reg;
    logic                     dens_sat_reg;
    logic [AVG_BITS-1:0]      avg_reg;
    logic [DENS_BITS-1:0]     dens_reg;

    logic                     out_valid_reg;
    logic [COUNT_BITS-1:0]    o_cell_reg;
    logic [COUNT_BITS-1:0]    o_max_reg;
    logic [UNIQUE_BITS-1:0]   o_unique_reg;
    logic [TOTAL_BITS-1:0]    o_total_reg;
    logic [AVG_BITS-1:0]      o_avg_reg;
    logic [DENS_BITS-1:0]     o_dens_reg;
    logic                     o_err_reg;

    logic [ADDR_BITS-1:0]     cell_addr;
    logic                     in_range;
    logic                     is_access;
    logic                     do_inc;
    logic [COUNT_BITS-1:0]    inc_cnt;
    logic                     mem_we;
    logic [ADDR_BITS-1:0]     mem_waddr;
    logic [COUNT_BITS-1:0]    mem_wdata;

    logic [CFG_DATA_BITS-1:0]   w_eff;
    logic [CFG_DATA_BITS-1:0]   h_eff;
    logic [2*CFG_DATA_BITS-1:0] area_full;
    logic [AREA_BITS-1:0]       area_c;
    logic [DENS_NUM_BITS-1:0]   dens_num_c;

    logic                    div_start;
    logic [DIV_R_BITS-1:0]   div_rem_init;
    logic [DIV_Q_BITS-1:0]   div_low_init;
    logic [DIV_CNT_BITS-1:0] div_steps;
    logic [DIV_R_BITS-1:0]   div_divisor;
    logic                    div_done;
    logic [DIV_Q_BITS-1:0]   div_quot;

    // configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_w_reg <= GRID_RESET;
            grid_h_reg <= GRID_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg_idx_t'(cfg.index))
                CFG_GRID_WIDTH:  grid_w_reg <= cfg.data;
                CFG_GRID_HEIGHT: grid_h_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg <= op_t'(in_opcode);
            x_reg  <= in_x;
            y_reg  <= in_y;
        end
    end

    // cell update
    assign cell_addr = {y_reg, x_reg};
    assign in_range  = (CFG_DATA_BITS'(x_reg) < grid_w_reg) && (CFG_DATA_BITS'(y_reg) < grid_h_reg);
    assign is_access = (op_reg == OP_RECORD) || (op_reg == OP_QUERY);
    assign do_inc    = (op_reg == OP_RECORD) && in_range && (rd_data_reg != COUNT_MAX);
    assign inc_cnt   = rd_data_reg + 1'b1;

    assign mem_we    = cmd.wipe_write || (cmd.upd_cell && do_inc);
    assign mem_waddr = cmd.wipe_write ? wipe_addr_reg : cell_addr;
    assign mem_wdata = cmd.wipe_write ? '0 : inc_cnt;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (cmd.rd_cell)
            rd_data_reg <= mem[cell_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wipe_addr_reg <= '0;
        else if (cmd.wipe_write)
            wipe_addr_reg <= wipe_addr_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg    <= '0;
            unique_reg <= '0;
            total_reg  <= '0;
        end
        else if (cmd.wipe_clear)
        begin
            max_reg    <= '0;
            unique_reg <= '0;
            total_reg  <= '0;
        end
        else if (cmd.upd_cell && do_inc)
        begin
            if (rd_data_reg == '0)
                unique_reg <= unique_reg + 1'b1;
            total_reg <= total_reg + 1'b1;
            if (inc_cnt > max_reg)
                max_reg <= inc_cnt;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wipe_clear)
        begin
            cell_reg <= '0;
            err_reg  <= 1'b0;
        end
        else if (cmd.upd_cell)
        begin
            if (is_access && in_range)
                cell_reg <= do_inc ? inc_cnt : rd_data_reg;
            else
                cell_reg <= '0;
            err_reg <= is_access && !in_range;
        end
    end

    // operands for the two divisions
    assign w_eff      = (grid_w_reg > CFG_DATA_BITS'(MAX_COLS)) ? CFG_DATA_BITS'(MAX_COLS) : grid_w_reg;
    assign h_eff      = (grid_h_reg > CFG_DATA_BITS'(MAX_ROWS)) ? CFG_DATA_BITS'(MAX_ROWS) : grid_h_reg;
    assign area_full  = (2*CFG_DATA_BITS)'(w_eff) * (2*CFG_DATA_BITS)'(h_eff);
    assign area_c     = area_full[AREA_BITS-1:0];
    assign dens_num_c = DENS_NUM_BITS'(unique_reg) * DENS_NUM_BITS'(DENSITY_FULL);

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            area_reg     <= area_c;
            dens_num_reg <= dens_num_c;
            dens_sat_reg <= unique_reg >= area_c;
        end
    end

    assign div_start    = cmd.avg_start || cmd.dens_start;
    assign div_rem_init = cmd.avg_start
                        ? DIV_R_BITS'(total_reg[TOTAL_BITS-1 -: TOTAL_BITS+Q8_BITS-AVG_BITS])
                        : dens_num_reg[DENS_NUM_BITS-1 -: DIV_R_BITS];
    assign div_low_init = cmd.avg_start
                        ? {total_reg[AVG_BITS-Q8_BITS-1:0], {Q8_BITS{1'b0}}}
                        : {dens_num_reg[DENS_BITS-1:0], {(DIV_Q_BITS-DENS_BITS){1'b0}}};
    assign div_steps    = cmd.avg_start ? DIV_CNT_BITS'(AVG_STEPS) : DIV_CNT_BITS'(DENS_STEPS);
    assign div_divisor  = cmd.avg_start ? unique_reg : area_reg;

    gvh_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .rem_init (div_rem_init),
        .low_init (div_low_init),
        .steps    (div_steps),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot     (div_quot)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.avg_cap)
            avg_reg <= (unique_reg == '0) ? '0 : div_quot;
        if (cmd.dens_cap)
        begin
            if (area_reg == '0)
                dens_reg <= '0;
            else if (dens_sat_reg)
                dens_reg <= DENS_BITS'(DENSITY_FULL);
            else
                dens_reg <= div_quot[DENS_BITS-1:0];
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            o_cell_reg   <= cell_reg;
            o_max_reg    <= max_reg;
            o_unique_reg <= unique_reg;
            o_total_reg  <= total_reg;
            o_avg_reg    <= avg_reg;
            o_dens_reg   <= dens_reg;
            o_err_reg    <= err_reg;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.cell_count    = o_cell_reg;
    assign rsp.max_visits    = o_max_reg;
    assign rsp.unique_cells  = o_unique_reg;
    assign rsp.total_visits  = o_total_reg;
    assign rsp.avg_visits_q8 = o_avg_reg;
    assign rsp.density_q8    = o_dens_reg;
    assign rsp.coord_error   = o_err_reg;

    assign sts.wipe_last = wipe_addr_reg == ADDR_BITS'(STORE_DEPTH - 1);
    assign sts.div_done  = div_done;
    assign sts.out_free  = !out_valid_reg || rsp.ready;

    a_upd_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.upd_cell |-> $past(cmd.rd_cell))
        else $error("cell update without a read the cycle before");

    a_max_unique: assert property (@(posedge clk) disable iff (!rst_n)
        (unique_reg == '0) == (max_reg == '0))
        else $error("running max and distinct count disagree on empty store");

    a_total_unique: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg >= TOTAL_BITS'(unique_reg))
        else $error("visit total below distinct count");

    a_dens_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.dens_cap |=> dens_reg <= DENS_BITS'(DENSITY_FULL))
        else $error("density above full coverage");

    a_avg_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.avg_cap && unique_reg == '0) |=> avg_reg == '0)
        else $error("average nonzero on empty store");

endmodule

// ----- design/gvh_ctrl.sv -----
// controller: sequences store sweep, cell access, divisions and result load
module gvh_ctrl import gvh_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [OP_BITS-1:0] in_opcode,
    output logic               in_ready,
    input  gvh_sts_t           sts,
    output gvh_cmd_t           cmd
);

    typedef enum logic [2:0] {
        S_WIPE,
        S_IDLE,
        S_READ,
        S_UPDATE,
        S_PREP,
        S_AVG,
        S_DENS,
        S_DONE
    } state_t;

    localparam gvh_cmd_t CMD_WIPE = '{wipe_write: 1'b1, default: 1'b0};

    state_t   state_reg;
    state_t   state_next;
    gvh_cmd_t cmd_reg;
    gvh_cmd_t cmd_next;
    logic     ready_reg;
    logic     ready_next;
    logic     wipe_item_reg;
    logic     wipe_item_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = '0;
        ready_next     = ready_reg;
        wipe_item_next = wipe_item_reg;
        case (state_reg)
            S_WIPE:
            begin
                if (sts.wipe_last)
                begin
                    if (wipe_item_reg)
                    begin
                        state_next    = S_PREP;
                        cmd_next.prep = 1'b1;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                        ready_next = 1'b1;
                    end
                end
                else
                    cmd_next.wipe_write = 1'b1;
            end
            S_IDLE:
            begin
                if (in_valid && ready_reg)
                begin
                    ready_next = 1'b0;
                    if (op_t'(in_opcode) == OP_CLEAR)
                    begin
                        state_next          = S_WIPE;
                        wipe_item_next      = 1'b1;
                        cmd_next.wipe_write = 1'b1;
                        cmd_next.wipe_clear = 1'b1;
                    end
                    else
                    begin
                        state_next       = S_READ;
                        cmd_next.rd_cell = 1'b1;
                    end
                end
            end
            S_READ:
            begin
                state_next        = S_UPDATE;
                cmd_next.upd_cell = 1'b1;
            end
            S_UPDATE:
            begin
                state_next    = S_PREP;
                cmd_next.prep = 1'b1;
            end
            S_PREP:
            begin
                state_next         = S_AVG;
                cmd_next.avg_start = 1'b1;
            end
            S_AVG:
            begin
                if (sts.div_done)
                begin
                    state_next          = S_DENS;
                    cmd_next.avg_cap    = 1'b1;
                    cmd_next.dens_start = 1'b1;
                end
            end
            S_DENS:
            begin
                if (sts.div_done)
                begin
                    state_next        = S_DONE;
                    cmd_next.dens_cap = 1'b1;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next        = S_IDLE;
                    cmd_next.load_out = 1'b1;
                    ready_next        = 1'b1;
                    wipe_item_next    = 1'b0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_WIPE;
            cmd_reg       <= CMD_WIPE;
            ready_reg     <= 1'b0;
            wipe_item_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            ready_reg     <= ready_next;
            wipe_item_reg <= wipe_item_next;
        end
    end

    assign in_ready = ready_reg;
    assign cmd      = cmd_reg;

endmodule

// ----- design/grid_visit_histogram_core.sv -----
// top level of the grid visit histogram
//
//  channel  dir  handshake      payload
//  req      in   valid/ready    opcode, cell_x, cell_y
//  rsp      out  valid/ready    cell_count, max_visits, unique_cells, total_visits,
//                               avg_visits_q8, density_q8, coord_error
//  cfg      in   valid/ready    index, data (0 grid width, 1 grid height)
//
//  record, query and no-op items run through the shared divider:
//  24 steps for the average, 15 for the coverage, plus store read and setup
//  a clear item sweeps all 4096 store entries at one a cycle, then runs the divisions
//  after reset the same sweep of all store entries runs before req is ready; cfg is taken always
//  a finished item waits in the result register while the next item is accepted
module grid_visit_histogram_core import gvh_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    gvh_req_if.sink   req,
    gvh_rsp_if.source rsp,
    gvh_cfg_if.sink   cfg
);

    gvh_cmd_t cmd;
    gvh_sts_t sts;
    logic     ready;
    logic     in_fire;

    assign req.ready = ready;
    assign in_fire   = req.valid && ready;

    gvh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_opcode (req.opcode),
        .in_ready  (ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    gvh_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_opcode (req.opcode),
        .in_x      (req.cell_x),
        .in_y      (req.cell_y),
        .cfg       (cfg),
        .rsp       (rsp),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// ----- tb/sv/grid_visit_histogram_core_tb.sv -----
// self-checking testbench for the grid visit histogram core
`timescale 1ns / 100ps

module grid_visit_histogram_core_tb import gvh_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT = 2000000;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_HI = 2'd3;

    typedef struct {
        op_t                 op;
        logic [COL_BITS-1:0] x;
        logic [ROW_BITS-1:0] y;
        bit                  drain;
    } grid_req_t;

    typedef struct {
        logic [COUNT_BITS-1:0]  cell_count;
        logic [COUNT_BITS-1:0]  max_visits;
        logic [UNIQUE_BITS-1:0] unique_cells;
        logic [TOTAL_BITS-1:0]  total_visits;
        logic [AVG_BITS-1:0]    avg_visits_q8;
        logic [DENS_BITS-1:0]   density_q8;
        logic                   coord_error;
    } grid_stats_t;

    logic clk = 1'b0;
    logic rst_n;

    gvh_req_if req_ch ();
    gvh_rsp_if rsp_ch ();
    gvh_cfg_if cfg_ch ();

    grid_visit_histogram_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // model state
    logic [COUNT_BITS-1:0]    visit_cnt [STORE_DEPTH];
    logic [COUNT_BITS-1:0]    peak_cnt;
    int unsigned              n_distinct;
    longint unsigned          n_visits;
    logic [CFG_DATA_BITS-1:0] grid_w;
    logic [CFG_DATA_BITS-1:0] grid_h;

    grid_req_t   visit_req_q [$];
    grid_stats_t stats_due_q [$];

    int unsigned push_cnt      = 0;
    int unsigned acc_cnt       = 0;
    int unsigned res_cnt       = 0;
    int unsigned bad_cnt       = 0;
    int unsigned cyc_cnt       = 0;
    int unsigned send_gap_pct  = 0;
    int unsigned rcv_stall_pct = 0;
    logic        req_took      = 1'b0;

    function automatic int unsigned eff_dim(int unsigned v, int unsigned lim);
        return (v > lim) ? lim : v;
    endfunction

    function automatic grid_stats_t histo_step(op_t op, logic [COL_BITS-1:0] x,
                                               logic [ROW_BITS-1:0] y);
        grid_stats_t     r;
        int unsigned     ew;
        int unsigned     eh;
        int unsigned     slot;
        longint unsigned area;
        longint unsigned dens;
        longint unsigned avg;
        ew = eff_dim(grid_w, MAX_COLS);
        eh = eff_dim(grid_h, MAX_ROWS);
        r.cell_count  = '0;
        r.coord_error = 1'b0;
        if (op == OP_RECORD || op == OP_QUERY)
        begin
            if (x < ew && y < eh)
            begin
                slot = y * MAX_COLS + x;
                if (op == OP_RECORD && visit_cnt[slot] != COUNT_MAX)
                begin
                    if (visit_cnt[slot] == '0)
                        n_distinct++;
                    visit_cnt[slot] = visit_cnt[slot] + 1'b1;
                    n_visits++;
                    if (visit_cnt[slot] > peak_cnt)
                        peak_cnt = visit_cnt[slot];
                end
                r.cell_count = visit_cnt[slot];
            end
            else
                r.coord_error = 1'b1;
        end
        else if (op == OP_CLEAR)
        begin
            foreach (visit_cnt[i])
                visit_cnt[i] = '0;
            peak_cnt   = '0;
            n_distinct = 0;
            n_visits   = 0;
        end
        avg  = 0;
        dens = 0;
        if (n_distinct != 0)
            avg = (n_visits * 256) / n_distinct;
        area = longint'(ew) * eh;
        if (area != 0)
        begin
            dens = (longint'(n_distinct) * DENSITY_FULL) / area;
            if (dens > DENSITY_FULL)
                dens = DENSITY_FULL;
        end
        r.max_visits    = peak_cnt;
        r.unique_cells  = UNIQUE_BITS'(n_distinct);
        r.total_visits  = TOTAL_BITS'(n_visits);
        r.avg_visits_q8 = AVG_BITS'(avg);
        r.density_q8    = DENS_BITS'(dens);
        return r;
    endfunction

    function automatic grid_req_t rand_req(int unsigned clear_pm);
        grid_req_t   q;
        int unsigned pick;
        int unsigned ew;
        int unsigned eh;
        ew   = eff_dim(grid_w, MAX_COLS);
        eh   = eff_dim(grid_h, MAX_ROWS);
        pick = $urandom_range(999);
        if (pick < clear_pm)
            q.op = OP_CLEAR;
        else if (pick < clear_pm + 60)
            q.op = OP_NOP;
        else if (pick < 330)
            q.op = OP_QUERY;
        else
            q.op = OP_RECORD;
        if (ew != 0 && eh != 0 && $urandom_range(99) < 85)
        begin
            q.x = COL_BITS'($urandom_range(ew - 1));
            q.y = ROW_BITS'($urandom_range(eh - 1));
        end
        else
        begin
            q.x = COL_BITS'($urandom_range(MAX_COLS - 1));
            q.y = ROW_BITS'($urandom_range(MAX_ROWS - 1));
        end
        q.drain = 1'b0;
        return q;
    endfunction

    task automatic report_bad(string what, longint unsigned got, longint unsigned want);
        $display("mismatch at result %0d: %s got %0d want %0d", res_cnt, what, got, want);
        bad_cnt++;
    endtask

    task automatic push_req(grid_req_t r);
        visit_req_q.push_back(r);
        push_cnt++;
    endtask

    task automatic wait_idle();
        while (acc_cnt != push_cnt || res_cnt != acc_cnt)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        if (idx == CFG_GRID_WIDTH)
            grid_w = val;
        else if (idx == CFG_GRID_HEIGHT)
            grid_h = val;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_phase(int unsigned n, int unsigned snd, int unsigned rcv,
                             int unsigned clear_pm);
        grid_req_t r;
        send_gap_pct  = snd;
        rcv_stall_pct = rcv;
        for (int unsigned i = 0; i < n; i++)
        begin
            r       = rand_req(clear_pm);
            r.drain = (i == n / 2);
            push_req(r);
        end
        wait_idle();
    endtask

    // driver: new item or gap at each falling edge once the last item was taken
    always @(negedge clk)
    begin : drive_proc
        grid_req_t nxt;
        logic      give;
        if (rst_n && (!req_ch.valid || req_took))
        begin
            give = 1'b0;
            if (visit_req_q.size() != 0 && $urandom_range(99) >= send_gap_pct &&
                !(visit_req_q[0].drain && res_cnt != acc_cnt))
            begin
                nxt  = visit_req_q.pop_front();
                give = 1'b1;
                req_ch.opcode <= nxt.op;
                req_ch.cell_x <= nxt.x;
                req_ch.cell_y <= nxt.y;
            end
            req_ch.valid <= give;
        end
        rsp_ch.ready <= rst_n && ($urandom_range(99) >= rcv_stall_pct);
    end

    // monitor: predict on accept, check on result
    always @(posedge clk)
    begin : watch_proc
        grid_stats_t want;
        cyc_cnt++;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                stats_due_q.push_back(histo_step(op_t'(req_ch.opcode), req_ch.cell_x,
                                                 req_ch.cell_y));
                acc_cnt++;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                res_cnt++;
                if (stats_due_q.size() == 0)
                    report_bad("unexpected item, pending", 0, 0);
                else
                begin
                    want = stats_due_q.pop_front();
                    if (rsp_ch.cell_count !== want.cell_count)
                        report_bad("cell_count", rsp_ch.cell_count, want.cell_count);
                    if (rsp_ch.max_visits !== want.max_visits)
                        report_bad("max_visits", rsp_ch.max_visits, want.max_visits);
                    if (rsp_ch.unique_cells !== want.unique_cells)
                        report_bad("unique_cells", rsp_ch.unique_cells, want.unique_cells);
                    if (rsp_ch.total_visits !== want.total_visits)
                        report_bad("total_visits", rsp_ch.total_visits, want.total_visits);
                    if (rsp_ch.avg_visits_q8 !== want.avg_visits_q8)
                        report_bad("avg_visits_q8", rsp_ch.avg_visits_q8, want.avg_visits_q8);
                    if (rsp_ch.density_q8 !== want.density_q8)
                        report_bad("density_q8", rsp_ch.density_q8, want.density_q8);
                    if (rsp_ch.coord_error !== want.coord_error)
                        report_bad("coord_error", rsp_ch.coord_error, want.coord_error);
                end
            end
        end
        req_took <= rst_n && req_ch.valid && req_ch.ready;
        if (cyc_cnt >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.opcode = OP_NOP;
        req_ch.cell_x = '0;
        req_ch.cell_y = '0;
        rsp_ch.ready  = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = CFG_GRID_WIDTH;
        cfg_ch.data   = '0;
        foreach (visit_cnt[i])
            visit_cnt[i] = '0;
        peak_cnt   = '0;
        n_distinct = 0;
        n_visits   = 0;
        grid_w     = GRID_RESET;
        grid_h     = GRID_RESET;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // corners, every opcode, clear in the middle
        push_req('{OP_QUERY,  6'd0,  6'd0,  1'b0});
        push_req('{OP_RECORD, 6'd0,  6'd0,  1'b0});
        push_req('{OP_RECORD, 6'd0,  6'd0,  1'b0});
        push_req('{OP_RECORD, 6'd63, 6'd63, 1'b0});
        push_req('{OP_QUERY,  6'd63, 6'd63, 1'b0});
        push_req('{OP_QUERY,  6'd0,  6'd0,  1'b0});
        push_req('{OP_NOP,    6'd63, 6'd63, 1'b0});
        push_req('{OP_RECORD, 6'd63, 6'd0,  1'b0});
        push_req('{OP_RECORD, 6'd0,  6'd63, 1'b0});
        push_req('{OP_QUERY,  6'd32, 6'd17, 1'b0});
        push_req('{OP_CLEAR,  6'd63, 6'd63, 1'b0});
        push_req('{OP_QUERY,  6'd0,  6'd0,  1'b0});
        push_req('{OP_RECORD, 6'd21, 6'd42, 1'b0});
        push_req('{OP_NOP,    6'd0,  6'd0,  1'b0});
        run_phase(150, 19, 47, 15);

        // single cell grid
        write_reg(CFG_GRID_WIDTH, 7'd1);
        write_reg(CFG_GRID_HEIGHT, 7'd1);
        push_req('{OP_QUERY,  6'd1, 6'd0, 1'b0});
        push_req('{OP_RECORD, 6'd0, 6'd1, 1'b0});
        run_phase(150, 19, 47, 10);

        // empty width, spare register slots ignored
        write_reg(CFG_GRID_WIDTH, 7'd0);
        write_reg(CFG_GRID_HEIGHT, 7'd12);
        write_reg(CFG_SPARE_LO, 7'd127);
        write_reg(CFG_SPARE_HI, 7'd0);
        push_req('{OP_RECORD, 6'd0, 6'd0, 1'b0});
        run_phase(60, 47, 19, 10);

        // oversize registers clip to the full grid
        write_reg(CFG_GRID_WIDTH, 7'd127);
        write_reg(CFG_GRID_HEIGHT, 7'd127);
        run_phase(200, 47, 19, 0);

        // shrunken grid keeps old counts, coverage saturates
        write_reg(CFG_GRID_WIDTH, 7'd8);
        write_reg(CFG_GRID_HEIGHT, 7'd3);
        push_req('{OP_QUERY,  6'd0, 6'd0, 1'b0});
        push_req('{OP_RECORD, 6'd8, 6'd0, 1'b0});
        push_req('{OP_RECORD, 6'd7, 6'd3, 1'b0});
        push_req('{OP_RECORD, 6'd7, 6'd2, 1'b0});
        run_phase(200, 0, 0, 10);

        write_reg(CFG_GRID_WIDTH, 7'd64);
        write_reg(CFG_GRID_HEIGHT, 7'd1);
        push_req('{OP_RECORD, 6'd63, 6'd0, 1'b0});
        push_req('{OP_QUERY,  6'd0,  6'd1, 1'b0});
        run_phase(300, 0, 0, 15);

        wait_idle();
        repeat (60) @(negedge clk);
        if (bad_cnt == 0 && stats_due_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- sim.f -----
design/gvh_pkg.sv
design/gvh_if.sv
design/gvh_div.sv
design/gvh_dp.sv
design/gvh_ctrl.sv
design/grid_visit_histogram_core.sv
tb/sv/grid_visit_histogram_core_tb.sv
